>>> design/sync_length_xor_frame_parser_defines.svh
// Assertion macros used by the frame parser checker.
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SLXFP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, disabled while reset is high.
`define SLXFP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

>>> design/slxfp_pkg.sv
// Shared types and constants for the sync/id/length/payload/XOR frame parser.
package slxfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SPEED_W  = 2 * BYTE_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FRAME_ID = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RST     = 8'hAA;
  localparam logic [BYTE_W-1:0] SPEED_FRAME_ID_RST = 8'h01;
  localparam logic [BYTE_W-1:0] MIN_SPEED_LENGTH   = 8'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_id;
    logic [BYTE_W-1:0]   payload_length;
    logic                speed_valid;
    logic [SPEED_W-1:0]  speed_value;
  } result_t;

endpackage

>>> design/sync_length_xor_frame_parser.sv
// Frame parser top level: sync, id, length, payload and XOR check byte.
// One received byte is taken per clock while item_stall is low. The parser
// state is updated in the cycle the byte is accepted and any report (ok,
// checksum mismatch, incomplete or invalid start) is registered for output.
// Throughput is one byte per cycle as long as the result side keeps up; a
// single skid entry behind the result register absorbs one stalled report,
// and byte intake pauses only while that entry is occupied. Bytes between a
// check byte and the next chunk start are dropped. Configuration writes are
// always taken (cfg_ready is tied high) and are meant for idle periods.
module sync_length_xor_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [slxfp_pkg::BYTE_W-1:0]    byte_value,
  input  logic                            chunk_start,
  input  logic                            chunk_end,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [slxfp_pkg::STATUS_W-1:0]  status,
  output logic [slxfp_pkg::BYTE_W-1:0]    frame_id,
  output logic [slxfp_pkg::BYTE_W-1:0]    payload_length,
  output logic                            speed_valid,
  output logic [slxfp_pkg::SPEED_W-1:0]   speed_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slxfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slxfp_pkg::BYTE_W-1:0]    cfg_data
);
  import slxfp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK,
    PH_DONE,
    PH_BAD
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic [BYTE_W-1:0] payload_remaining, payload_remaining_next;
  logic [BYTE_W-1:0] held_id, held_id_next;
  logic [BYTE_W-1:0] held_length, held_length_next;
  logic [BYTE_W-1:0] speed_high, speed_high_next;
  logic [BYTE_W-1:0] speed_low, speed_low_next;
  logic [BYTE_W-1:0] sync_value;
  logic [BYTE_W-1:0] speed_frame_id;
  logic [BYTE_W-1:0] payload_pos;

  logic    item_accept;
  logic    res_fire;
  logic    end_check;
  logic    check_ok;
  result_t res;
  result_t out_r;
  result_t skid_r;
  logic    skid_valid;
  logic    out_free;

  assign item_accept = item_valid && !item_stall;
  assign item_stall  = skid_valid;
  assign cfg_ready   = 1'b1;
  assign payload_pos = held_length - payload_remaining;
  assign check_ok    = (byte_value == running_xor);

  always_comb begin
    phase_next             = phase;
    running_xor_next       = running_xor;
    payload_remaining_next = payload_remaining;
    held_id_next           = held_id;
    held_length_next       = held_length;
    speed_high_next        = speed_high;
    speed_low_next         = speed_low;
    res_fire               = 1'b0;
    end_check              = 1'b0;
    res                    = '0;
    res.status             = ST_OK;

    if (chunk_start) begin
      running_xor_next       = '0;
      payload_remaining_next = '0;
      held_id_next           = '0;
      held_length_next       = '0;
      speed_high_next        = '0;
      speed_low_next         = '0;
      end_check              = 1'b1;
      if (byte_value == sync_value) begin
        running_xor_next = byte_value;
        phase_next       = PH_ID;
      end else begin
        phase_next = PH_BAD;
      end
    end else begin
      unique case (phase)
        PH_BAD: begin
          if (chunk_end) begin
            phase_next = PH_IDLE;
            res_fire   = 1'b1;
            res.status = ST_INVALID;
          end
        end
        PH_ID: begin
          held_id_next     = byte_value;
          running_xor_next = running_xor ^ byte_value;
          phase_next       = PH_LEN;
          end_check        = 1'b1;
        end
        PH_LEN: begin
          held_length_next       = byte_value;
          payload_remaining_next = byte_value;
          running_xor_next       = running_xor ^ byte_value;
          phase_next             = (byte_value != '0) ? PH_PAYLOAD : PH_CHECK;
          end_check              = 1'b1;
        end
        PH_PAYLOAD: begin
          if (payload_pos == BYTE_W'(0)) begin
            speed_high_next = byte_value;
          end else if (payload_pos == BYTE_W'(1)) begin
            speed_low_next = byte_value;
          end
          running_xor_next       = running_xor ^ byte_value;
          payload_remaining_next = payload_remaining - BYTE_W'(1);
          if (payload_remaining == BYTE_W'(1)) begin
            phase_next = PH_CHECK;
          end
          end_check = 1'b1;
        end
        PH_CHECK: begin
          phase_next         = PH_DONE;
          res_fire           = 1'b1;
          res.status         = check_ok ? ST_OK : ST_MISMATCH;
          res.frame_id       = held_id;
          res.payload_length = held_length;
          res.speed_valid    = check_ok && (held_id == speed_frame_id) &&
                               (held_length >= MIN_SPEED_LENGTH);
          res.speed_value    = res.speed_valid ? {speed_high, speed_low} : '0;
        end
        PH_IDLE, PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    // chunk ended before the check byte: incomplete, or invalid on a bad sync byte
    if (end_check && chunk_end) begin
      res_fire   = 1'b1;
      phase_next = PH_IDLE;
      if (!chunk_start || byte_value == sync_value) begin
        res.status         = ST_INCOMPL;
        res.frame_id       = held_id_next;
        res.payload_length = held_length_next;
      end else begin
        res.status = ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      sync_value     <= SYNC_VALUE_RST;
      speed_frame_id <= SPEED_FRAME_ID_RST;
    end else begin
      if (item_accept) begin
        phase <= phase_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SYNC_VALUE:     sync_value     <= cfg_data;
          CFG_SPEED_FRAME_ID: speed_frame_id <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor       <= '0;
      payload_remaining <= '0;
      held_id           <= '0;
      held_length       <= '0;
      speed_high        <= '0;
      speed_low         <= '0;
    end else if (item_accept) begin
      running_xor       <= running_xor_next;
      payload_remaining <= payload_remaining_next;
      held_id           <= held_id_next;
      held_length       <= held_length_next;
      speed_high        <= speed_high_next;
      speed_low         <= speed_low_next;
    end
  end

  // result register with one skid entry behind it
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= item_accept && res_fire;
      end
    end else if (item_accept && res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid ? skid_r : res;
    end else if (item_accept && res_fire) begin
      skid_r <= res;
    end
  end

  assign status         = out_r.status;
  assign frame_id       = out_r.frame_id;
  assign payload_length = out_r.payload_length;
  assign speed_valid    = out_r.speed_valid;
  assign speed_value    = out_r.speed_value;

endmodule

>>> design/slxfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`include "sync_length_xor_frame_parser_defines.svh"

module slxfp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [slxfp_pkg::STATUS_W-1:0] status,
  input logic [slxfp_pkg::BYTE_W-1:0]   frame_id,
  input logic [slxfp_pkg::BYTE_W-1:0]   payload_length,
  input logic                           speed_valid,
  input logic [slxfp_pkg::SPEED_W-1:0]  speed_value
);
  import slxfp_pkg::*;

  // speed is only reported on a good checksum
  `SLXFP_ASSERT_NOW(a_speed_needs_ok, clk, rst, result_valid && speed_valid, status == ST_OK)
  // no speed value leaks out without its valid flag
  `SLXFP_ASSERT_NOW(a_speed_zero, clk, rst, result_valid && !speed_valid, speed_value == '0)
  // a bad start carries no id or length
  `SLXFP_ASSERT_NOW(a_invalid_clear, clk, rst, result_valid && status == ST_INVALID, frame_id == '0 && payload_length == '0)
  // a stalled transaction holds
  `SLXFP_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(status) && $stable(frame_id) && $stable(payload_length) && $stable(speed_value))

endmodule

bind sync_length_xor_frame_parser slxfp_checker u_slxfp_checker (.*);
